// ----- rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the shell line tokenizer
// Result record layout, event and token type codes, character codes.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int W_IDX = 9;
    localparam int W_TOK = 5;
    localparam int QD    = 2;
    localparam int Q_AW  = $clog2(QD);

    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_FIN  = 2'd1;
    localparam logic [1:0] EV_DONE = 2'd2;
    localparam logic [1:0] EV_ERR  = 2'd3;

    localparam logic [1:0] TT_WORD = 2'd0;
    localparam logic [1:0] TT_AMP  = 2'd1;
    localparam logic [1:0] TT_LT   = 2'd2;
    localparam logic [1:0] TT_GT   = 2'd3;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;

    typedef struct packed {
        logic [1:0]       ev;
        logic [7:0]       byte_value;
        logic [W_IDX-1:0] buffer_index;
        logic [W_TOK-1:0] token_number;
        logic [W_IDX-1:0] token_start;
        logic [1:0]       token_type;
    } t_rec;

    typedef struct packed {
        logic [1:0]       cnt;
        t_rec [2:0]       rec;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- rtl/shell_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// shell_line_tokenizer: command line lexer
// Splits a command line, one character word at a time, into token records.
// ----------------------------------------------------------------------------
// A character is accepted in any cycle in which the two-bundle result queue
// has room; the lexer state updates in that same cycle, so characters that
// cause no result (blanks, opening quotes, discarded input) flow at one per
// cycle. Each character yields zero to three result words, which pass through
// the queue into the output register and leave it one per cycle while the
// output is not stalled: typically one result, two for an operator or for a
// line end right after a word, three for an ampersand right after a word.
// There is no clearing pass after reset.
module shell_line_tokenizer #(
    parameter int MAX_TOKENS  = 16,
    parameter int LINE_LENGTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_character,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_res,
    output logic [7:0] o_byte_value,
    output logic [8:0] o_buffer_index,
    output logic [4:0] o_token_number,
    output logic [8:0] o_token_start,
    output logic [1:0] o_token_type,
    output logic       o_last
);
    import slt_pkg::*;

    t_push   push;
    t_qstat  qstat;
    t_bundle head;
    logic    pop;
    t_rec    rec;

    slt_front #(
        .MAX_TOKENS  (MAX_TOKENS),
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_character (i_character),
        .o_stall     (o_stall),
        .i_qstat     (qstat),
        .o_push      (push)
    );

    slt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head)
    );

    slt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rec   (rec),
        .o_last  (o_last)
    );

    assign o_event_res    = rec.ev;
    assign o_byte_value   = rec.byte_value;
    assign o_buffer_index = rec.buffer_index;
    assign o_token_number = rec.token_number;
    assign o_token_start  = rec.token_start;
    assign o_token_type   = rec.token_type;

endmodule

// ----- rtl/slt_front.sv -----
// ----------------------------------------------------------------------------
// slt_front: character classifier and lexer state
// Takes one character word per cycle while the result queue has room and pushes its bundle of results, if any.
// ----------------------------------------------------------------------------
module slt_front #(
    parameter int MAX_TOKENS  = 16,
    parameter int LINE_LENGTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_character,
    output logic           o_stall,
    input  slt_pkg::t_qstat i_qstat,
    output slt_pkg::t_push  o_push
);
    import slt_pkg::*;

    localparam int BUF_SIZE = LINE_LENGTH + MAX_TOKENS;
    localparam int IDX_W    = $clog2(BUF_SIZE + 2);
    localparam int TC_W     = $clog2(MAX_TOKENS + 1);

    localparam logic [IDX_W-1:0] BUF_LIM = IDX_W'(BUF_SIZE);
    localparam logic [IDX_W-1:0] BUF_M1  = IDX_W'(BUF_SIZE - 1);
    localparam logic [TC_W-1:0]  TC_MAX  = TC_W'(MAX_TOKENS);

    typedef enum logic [3:0] {
        M_BETWEEN = 4'b0001,
        M_WORD    = 4'b0010,
        M_QUOTE   = 4'b0100,
        M_DISCARD = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [1:0]       cnt;
        t_rec             ra;
        t_rec             rb;
        t_mode            mode;
        logic [IDX_W-1:0] wi;
        logic [TC_W-1:0]  tc;
        logic [IDX_W-1:0] cs;
        logic             qd;
    } t_btw;

    t_mode            r_mode,  n_mode;
    logic             r_qd,    n_qd;
    logic [TC_W-1:0]  r_tc,    n_tc;
    logic [IDX_W-1:0] r_wi,    n_wi;
    logic [IDX_W-1:0] r_cs,    n_cs;
    t_bundle          n_bundle;
    logic             accept;

    function automatic t_rec f_rec(input logic [1:0] ev, input logic [7:0] ch,
                                   input logic [IDX_W-1:0] wi, input logic [TC_W-1:0] tc,
                                   input logic [IDX_W-1:0] st, input logic [1:0] ty);
        t_rec r;
        r.ev           = ev;
        r.byte_value   = ch;
        r.buffer_index = W_IDX'(wi);
        r.token_number = W_TOK'(tc);
        r.token_start  = W_IDX'(st);
        r.token_type   = ty;
        return r;
    endfunction

    function automatic t_btw f_between(input logic [7:0] ch, input logic term,
                                       input logic [IDX_W-1:0] wb, input logic [TC_W-1:0] tb,
                                       input logic [IDX_W-1:0] cs, input logic qd);
        t_btw       b;
        logic [1:0] ty;
        b      = '0;
        b.mode = M_BETWEEN;
        b.wi   = wb;
        b.tc   = tb;
        b.cs   = cs;
        b.qd   = qd;
        ty     = (ch == CH_AMP) ? TT_AMP : (ch == CH_LT) ? TT_LT : TT_GT;
        priority if (term) begin
            b.cnt = 2'd1;
            b.ra  = f_rec(EV_DONE, CH_NUL, wb, tb, '0, TT_WORD);
            b.wi  = '0;
            b.tc  = '0;
            b.cs  = '0;
            b.qd  = 1'b0;
        end else if (tb >= TC_MAX) begin
            b.cnt  = 2'd1;
            b.ra   = f_rec(EV_ERR, CH_NUL, wb, tb, '0, TT_WORD);
            b.mode = M_DISCARD;
        end else if (ch == CH_SP || ch == CH_TAB) begin
            b.cnt = 2'd0;
        end else if (ch == CH_AMP || ch == CH_LT || ch == CH_GT) begin
            b.cs = wb;
            if (wb >= BUF_LIM) begin
                b.cnt  = 2'd1;
                b.ra   = f_rec(EV_ERR, CH_NUL, wb, tb, '0, TT_WORD);
                b.mode = M_DISCARD;
            end else begin
                b.cnt = 2'd2;
                b.ra  = f_rec(EV_BYTE, ch, wb, tb, wb, ty);
                if (wb >= BUF_M1) begin
                    b.rb   = f_rec(EV_ERR, CH_NUL, wb + 1'b1, tb, '0, TT_WORD);
                    b.wi   = wb + 1'b1;
                    b.mode = M_DISCARD;
                end else begin
                    b.rb = f_rec(EV_FIN, CH_NUL, wb + 1'b1, tb, wb, ty);
                    b.wi = wb + IDX_W'(2);
                    b.tc = tb + 1'b1;
                end
            end
        end else if (ch == CH_SQ || ch == CH_DQ) begin
            b.cs   = wb;
            b.qd   = (ch == CH_DQ);
            b.mode = M_QUOTE;
        end else begin
            b.cs   = wb;
            b.mode = M_WORD;
            b.cnt  = 2'd1;
            if (wb >= BUF_LIM) begin
                b.ra   = f_rec(EV_ERR, CH_NUL, wb, tb, '0, TT_WORD);
                b.mode = M_DISCARD;
            end else begin
                b.ra = f_rec(EV_BYTE, ch, wb, tb, wb, TT_WORD);
                b.wi = wb + 1'b1;
            end
        end
        return b;
    endfunction

    assign accept  = i_valid && !i_qstat.full;
    assign o_stall = i_qstat.full;

    always_comb begin
        t_btw       b;
        logic       term;
        logic [7:0] closer;
        b        = '0;
        term     = (i_character == CH_NUL) || (i_character == CH_LF);
        closer   = r_qd ? CH_DQ : CH_SQ;
        n_mode   = r_mode;
        n_qd     = r_qd;
        n_tc     = r_tc;
        n_wi     = r_wi;
        n_cs     = r_cs;
        n_bundle = '0;
        unique case (r_mode)
            M_BETWEEN: begin
                b             = f_between(i_character, term, r_wi, r_tc, r_cs, r_qd);
                n_bundle.cnt  = b.cnt;
                n_bundle.rec[0] = b.ra;
                n_bundle.rec[1] = b.rb;
                n_mode        = b.mode;
                n_wi          = b.wi;
                n_tc          = b.tc;
                n_cs          = b.cs;
                n_qd          = b.qd;
            end
            M_WORD: begin
                n_bundle.cnt = 2'd1;
                priority if (term || i_character == CH_SP || i_character == CH_TAB
                             || i_character == CH_AMP) begin
                    if (r_wi >= BUF_LIM) begin
                        n_bundle.rec[0] = f_rec(EV_ERR, CH_NUL, r_wi, r_tc, '0, TT_WORD);
                        if (term) begin
                            n_mode = M_BETWEEN;
                            n_wi   = '0;
                            n_tc   = '0;
                            n_cs   = '0;
                            n_qd   = 1'b0;
                        end else begin
                            n_mode = M_DISCARD;
                        end
                    end else begin
                        b = f_between(i_character, term, r_wi + 1'b1, r_tc + 1'b1,
                                      r_cs, r_qd);
                        n_bundle.rec[0] = f_rec(EV_FIN, CH_NUL, r_wi, r_tc, r_cs, TT_WORD);
                        n_bundle.rec[1] = b.ra;
                        n_bundle.rec[2] = b.rb;
                        n_bundle.cnt    = 2'd1 + b.cnt;
                        n_mode          = b.mode;
                        n_wi            = b.wi;
                        n_tc            = b.tc;
                        n_cs            = b.cs;
                        n_qd            = b.qd;
                    end
                end else if (i_character == CH_SQ || i_character == CH_DQ
                             || i_character == CH_LT || i_character == CH_GT) begin
                    n_bundle.rec[0] = f_rec(EV_ERR, CH_NUL, r_wi, r_tc, '0, TT_WORD);
                    n_mode          = M_DISCARD;
                end else if (r_wi >= BUF_LIM) begin
                    n_bundle.rec[0] = f_rec(EV_ERR, CH_NUL, r_wi, r_tc, '0, TT_WORD);
                    n_mode          = M_DISCARD;
                end else begin
                    n_bundle.rec[0] = f_rec(EV_BYTE, i_character, r_wi, r_tc, r_cs, TT_WORD);
                    n_wi            = r_wi + 1'b1;
                end
            end
            M_QUOTE: begin
                n_bundle.cnt = 2'd1;
                priority if (term) begin
                    n_bundle.rec[0] = f_rec(EV_ERR, CH_NUL, r_wi, r_tc, '0, TT_WORD);
                    n_mode          = M_BETWEEN;
                    n_wi            = '0;
                    n_tc            = '0;
                    n_cs            = '0;
                    n_qd            = 1'b0;
                end else if (r_wi >= BUF_LIM) begin
                    n_bundle.rec[0] = f_rec(EV_ERR, CH_NUL, r_wi, r_tc, '0, TT_WORD);
                    n_mode          = M_DISCARD;
                end else if (i_character == closer) begin
                    n_bundle.rec[0] = f_rec(EV_FIN, CH_NUL, r_wi, r_tc, r_cs, TT_WORD);
                    n_wi            = r_wi + 1'b1;
                    n_tc            = r_tc + 1'b1;
                    n_mode          = M_BETWEEN;
                end else begin
                    n_bundle.rec[0] = f_rec(EV_BYTE, i_character, r_wi, r_tc, r_cs, TT_WORD);
                    n_wi            = r_wi + 1'b1;
                end
            end
            M_DISCARD: begin
                if (term) begin
                    n_mode = M_BETWEEN;
                    n_wi   = '0;
                    n_tc   = '0;
                    n_cs   = '0;
                    n_qd   = 1'b0;
                end
            end
            default: begin
                n_mode = M_BETWEEN;
                n_wi   = '0;
                n_tc   = '0;
                n_cs   = '0;
                n_qd   = 1'b0;
            end
        endcase
    end

    assign o_push.valid  = accept && (n_bundle.cnt != 2'd0);
    assign o_push.bundle = n_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
            r_qd   <= 1'b0;
            r_tc   <= '0;
            r_wi   <= '0;
            r_cs   <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_qd   <= n_qd;
            r_tc   <= n_tc;
            r_wi   <= n_wi;
            r_cs   <= n_cs;
        end
    end

endmodule

// ----- rtl/slt_queue.sv -----
// ----------------------------------------------------------------------------
// slt_queue: result bundle queue
// Two-entry register FIFO between the lexer front end and the output stage.
// ----------------------------------------------------------------------------
module slt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slt_pkg::t_push   i_push,
    input  logic             i_pop,
    output slt_pkg::t_qstat  o_qstat,
    output slt_pkg::t_bundle o_head
);
    import slt_pkg::*;

    t_bundle           r_mem [QD];
    logic [Q_AW-1:0]   r_wp, n_wp;
    logic [Q_AW-1:0]   r_rp, n_rp;
    logic [Q_AW:0]     r_count, n_count;
    logic              push;
    logic              pop;

    assign o_qstat.full  = (r_count == (Q_AW + 1)'(QD));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rp];

    assign push = i_push.valid && !o_qstat.full;
    assign pop  = i_pop && !o_qstat.empty;

    always_comb begin
        n_wp    = push ? ((r_wp == Q_AW'(QD - 1)) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp    = pop  ? ((r_rp == Q_AW'(QD - 1)) ? '0 : r_rp + 1'b1) : r_rp;
        n_count = r_count + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.bundle;
        end
    end

endmodule

// ----- rtl/slt_back.sv -----
// ----------------------------------------------------------------------------
// slt_back: result serializer
// Unpacks the head bundle one result per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module slt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slt_pkg::t_qstat  i_qstat,
    input  slt_pkg::t_bundle i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output slt_pkg::t_rec    o_rec,
    output logic             o_last
);
    import slt_pkg::*;

    logic [1:0] r_sel, n_sel;
    logic       r_valid;
    t_rec       r_rec;
    logic       r_last;
    logic       load;
    logic       is_last;

    assign load    = !i_qstat.empty && (!r_valid || !i_stall);
    assign is_last = (r_sel == i_head.cnt - 2'd1);
    assign n_sel   = is_last ? 2'd0 : r_sel + 2'd1;
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= n_sel;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec  <= i_head.rec[r_sel];
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign o_last  = r_last;

endmodule

// ----- rtl/slt_checker.sv -----
// ----------------------------------------------------------------------------
// slt_checker: port-level checks of the shell line tokenizer
// Watches the input and output channels and the record fields over time.
// ----------------------------------------------------------------------------
module slt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_character,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_event_res,
    input logic [7:0] o_byte_value,
    input logic [8:0] o_buffer_index,
    input logic [4:0] o_token_number,
    input logic [8:0] o_token_start,
    input logic [1:0] o_token_type,
    input logic       o_last
);
    import slt_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_character))
        else $error("stalled character word changed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_res) && $stable(o_byte_value)
            && $stable(o_buffer_index) && $stable(o_token_number)
            && $stable(o_token_start) && $stable(o_token_type) && $stable(o_last))
        else $error("stalled result word changed");

    a_line_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_DONE || o_event_res == EV_ERR)
            |-> o_byte_value == 8'd0 && o_token_start == 9'd0 && o_token_type == TT_WORD)
        else $error("line done or error carries token fields");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_DONE |-> o_last)
        else $error("line done is not the final result of its character");

    a_op_byte_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_BYTE && o_token_type != TT_WORD
            |-> o_buffer_index == o_token_start)
        else $error("operator byte not at its token start");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_character    (i_character),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_event_res    (o_event_res),
    .o_byte_value   (o_byte_value),
    .o_buffer_index (o_buffer_index),
    .o_token_number (o_token_number),
    .o_token_start  (o_token_start),
    .o_token_type   (o_token_type),
    .o_last         (o_last)
);
